### src/plt_pkg.sv
package plt_pkg;

  // Default number of list slots.
  localparam int unsigned DEPTH_DEF = 64;

  // Field widths of the stream payloads.
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned IDENT_W    = 32;
  localparam int unsigned PAYLOAD_W  = 64;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned HIT_POS_W  = 6;
  localparam int unsigned TOTAL_W    = 7;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 112;

  // Requested operation.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 3'd0,
    STATUS_EMPTY = 3'd1,
    STATUS_RANGE = 3'd2,
    STATUS_FULL  = 3'd3,
    STATUS_MISS  = 3'd4
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_START,
    OP_STEP
  } cell_op_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // One list entry.
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [IDENT_W-1:0]   ident;
  } entry_t;

  // Control group from the controller to the cells.
  typedef struct packed {
    cell_op_e             op;
    logic [IDENT_W-1:0]   key;
    entry_t               ins;
  } cell_ctrl_t;

endpackage

### src/plt_cell.sv
module plt_cell #(
  parameter int unsigned CmpW = 7,
  parameter int unsigned Idx  = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plt_pkg::cell_ctrl_t ctrl_i,
  input  logic [CmpW-1:0]    pos_i,
  input  logic [CmpW-1:0]    count_i,
  input  plt_pkg::entry_t    below_i,
  input  plt_pkg::entry_t    above_i,
  input  logic               tok_i,
  output plt_pkg::entry_t    entry_o,
  output logic               tok_o,
  output logic               miss_o,
  output logic               sel_o,
  output plt_pkg::entry_t    rd_o
);
  import plt_pkg::*;

  localparam logic [CmpW-1:0] MyIdx   = CmpW'(Idx);
  localparam logic [CmpW-1:0] NextIdx = CmpW'(Idx + 1);

  entry_t entry_q, entry_d;
  logic   tok_q, tok_d;
  logic   match, next_live, hit, rm_sel;

  // Local compare against the search key and the list length.
  assign match     = (entry_q.ident == ctrl_i.key);
  assign next_live = (NextIdx < count_i);
  assign hit       = tok_q & match;
  assign rm_sel    = (ctrl_i.op == OP_REMOVE) && (MyIdx == pos_i);

  assign tok_o   = tok_q & ~match & next_live;
  assign miss_o  = tok_q & ~match & ~next_live;
  assign sel_o   = hit | rm_sel;
  assign rd_o    = sel_o ? entry_q : '0;
  assign entry_o = entry_q;

  // Shift from a neighbor or take the new entry, and load or pass on the search token.
  always_comb begin
    entry_d = entry_q;
    tok_d   = tok_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (MyIdx > pos_i) begin
          entry_d = below_i;
        end else if (MyIdx == pos_i) begin
          entry_d = ctrl_i.ins;
        end
      end
      OP_REMOVE: begin
        if (MyIdx >= pos_i) begin
          entry_d = above_i;
        end
      end
      OP_START: tok_d = (Idx == 0);
      OP_STEP:  tok_d = tok_i;
      default:  ;
    endcase
  end

  // Search token.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### src/positional_list_table_core.sv
// Ordered list of up to DEPTH entries (32-bit identity, 64-bit payload).
// Input stream: s_axis_tuser carries the operation (insert at position,
// remove at position, search by identity); s_axis_tdata carries position,
// identity and payload. Every transaction yields exactly one result on the
// master stream: status, hit slot, hit identity, hit payload and the new
// entry count.
// For insert, remove, rejected operations and searches of an empty list
// the result is registered at the edge that accepts the item, and a new
// item can be taken every cycle while the output register is free. A
// search walks a token along the chain of cells from slot 0, one cell per
// cycle while the output is free; a hit ends the walk, as does a miss at
// the last live slot, and no new item is taken meanwhile.
// Reset empties the list. When the receiver stalls, the result stays in
// the output register, the search token freezes and the input is held off
// until the register is free (or is being drained in the same cycle).
module positional_list_table_core #(
  parameter int unsigned DEPTH = plt_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [6:0] position, [38:7] ident, [102:39] payload, [103] zero
  input  logic [plt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [plt_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] status, [8:3] hit_position, [40:9] hit_ident,
  // [104:41] hit_payload, [111:105] entry_total
  output logic [plt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import plt_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;
  localparam int unsigned ExtW = (IdxW > HIT_POS_W) ? IdxW : HIT_POS_W;
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IDENT_W-1:0] key_q, key_d;
  logic             m_vld_q;
  logic [OUT_DATA_W-1:0] m_data_q, res_data;
  logic             load_out, out_free, acc;

  logic [POS_W-1:0]     in_pos;
  logic [IDENT_W-1:0]   in_ident;
  logic [PAYLOAD_W-1:0] in_payload;
  kind_e                in_kind;
  logic [CmpW-1:0]      pos_ext, cnt_ext;

  cell_ctrl_t ctrl;
  entry_t     ent   [DEPTH];
  entry_t     rd    [DEPTH];
  logic       tok   [DEPTH];
  logic [DEPTH-1:0] miss_v, sel_v;

  entry_t           rd_ent;
  logic [IdxW-1:0]  rd_idx;
  logic [ExtW-1:0]  rd_idx_ext;
  logic             hit_any, miss_any;

  status_e              r_status;
  logic [HIT_POS_W-1:0] r_pos;
  entry_t               r_ent;
  logic [CntW-1:0]      r_cnt;
  logic [CmpW-1:0]      r_cnt_ext;

  // Input field unpacking.
  assign in_pos     = s_axis_tdata[6:0];
  assign in_ident   = s_axis_tdata[38:7];
  assign in_payload = s_axis_tdata[102:39];
  assign in_kind    = kind_e'(s_axis_tuser);
  assign pos_ext    = CmpW'(in_pos);
  assign cnt_ext    = CmpW'(cnt_q);

  assign out_free      = !m_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Chain of cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t below, above;
    logic   tok_in;
    if (i == 0) begin : g_first
      assign below  = '0;
      assign tok_in = 1'b0;
    end else begin : g_mid
      assign below  = ent[i-1];
      assign tok_in = tok[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = '0;
    end else begin : g_up
      assign above = ent[i+1];
    end

    plt_cell #(
      .CmpW (CmpW),
      .Idx  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .pos_i   (pos_ext),
      .count_i (cnt_ext),
      .below_i (below),
      .above_i (above),
      .tok_i   (tok_in),
      .entry_o (ent[i]),
      .tok_o   (tok[i]),
      .miss_o  (miss_v[i]),
      .sel_o   (sel_v[i]),
      .rd_o    (rd[i])
    );
  end

  // One-hot read-out of the selected cell.
  always_comb begin
    rd_ent = '0;
    rd_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_ent = rd_ent | rd[i];
      if (sel_v[i]) begin
        rd_idx = rd_idx | IdxW'(i);
      end
    end
  end

  assign rd_idx_ext = ExtW'(rd_idx);
  assign hit_any    = |sel_v;
  assign miss_any   = |miss_v;

  // Controller: operation decode, search sequencing and result build.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    key_d        = key_q;
    load_out     = 1'b0;
    ctrl.op      = OP_NONE;
    ctrl.key     = key_q;
    ctrl.ins     = '{payload: in_payload, ident: in_ident};
    r_status     = STATUS_OK;
    r_pos        = '0;
    r_ent        = '0;
    r_cnt        = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          load_out = 1'b1;
          unique case (in_kind)
            KIND_INSERT: begin
              if (cnt_q == Full) begin
                r_status = STATUS_FULL;
              end else if (pos_ext > cnt_ext) begin
                r_status = STATUS_RANGE;
              end else begin
                ctrl.op = OP_INSERT;
                cnt_d   = cnt_q + 1'b1;
                r_cnt   = cnt_d;
              end
            end
            KIND_REMOVE: begin
              if (cnt_q == '0) begin
                r_status = STATUS_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                r_status = STATUS_RANGE;
              end else begin
                ctrl.op = OP_REMOVE;
                cnt_d   = cnt_q - 1'b1;
                r_cnt   = cnt_d;
                r_pos   = in_pos[HIT_POS_W-1:0];
                r_ent   = rd_ent;
              end
            end
            KIND_SEARCH: begin
              if (cnt_q == '0) begin
                r_status = STATUS_MISS;
              end else begin
                load_out = 1'b0;
                ctrl.op  = OP_START;
                key_d    = in_ident;
                state_d  = ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (out_free) begin
          ctrl.op = OP_STEP;
          if (hit_any) begin
            load_out = 1'b1;
            r_pos    = rd_idx_ext[HIT_POS_W-1:0];
            r_ent    = rd_ent;
            state_d  = ST_IDLE;
          end else if (miss_any) begin
            load_out = 1'b1;
            r_status = STATUS_MISS;
            state_d  = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result packing.
  assign r_cnt_ext = CmpW'(r_cnt);
  assign res_data  = {r_cnt_ext[TOTAL_W-1:0], r_ent.payload, r_ent.ident, r_pos, r_status};

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      m_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // Search key and output payload.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (load_out) begin
      m_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

endmodule
